>>> rtl/core/wnls_pkg.sv
package wnls_pkg;

  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned LogEntriesDef = 256;
  localparam int unsigned FieldW        = 24;
  localparam int unsigned WeightW       = 17;
  localparam int unsigned SumW          = 64;
  localparam logic [31:0] Ln2Q32        = 32'd2977044472;
  localparam logic [63:0] HalfLn2PiQ32  = 64'd3946810947;

  // One classified transaction handed from the front part to the back part.
  typedef struct packed {
    logic [47:0] dmag_scaled;  // |theta - mean| << F
    logic [23:0] sd;           // sd with zero replaced by one
    logic [WeightW-1:0] weight;
    logic last;
  } front_item_t;

  // Table entry i: log2(1 + i/entries) in Q0.16, squaring method.
  function automatic logic [15:0] frac_log2(input int unsigned i, input int unsigned n);
    logic [63:0] x;
    logic [15:0] r;
    x = (64'd1 << 30) + ((64'(i) << 30) / 64'(n));
    r = '0;
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 30;
      r = {r[14:0], 1'b0};
      if (x >= (64'd1 << 31)) begin
        r[0] = 1'b1;
        x = x >> 1;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/wnls_front.sv
module wnls_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic signed [23:0]          trait_i,
  input  logic signed [23:0]          mean_i,
  input  logic [23:0]                 sd_i,
  input  logic [16:0]                 weight_i,
  input  logic                        last_i,
  output logic                        q_valid_o,
  input  logic                        q_ready_i,
  output wnls_pkg::front_item_t       q_item_o
);
  import wnls_pkg::*;

  parameter int unsigned FracBits = FracBitsDef;

  // Two-entry queue toward the back part.
  front_item_t mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop;
  front_item_t it;
  logic signed [24:0] diff;
  logic [24:0] dmag;

  always_comb begin
    diff = 25'(trait_i) - 25'(mean_i);
    dmag = diff[24] ? 25'(-diff) : diff;
    it.dmag_scaled = 48'(dmag) << FracBits;
    it.sd          = (sd_i == '0) ? 24'd1 : sd_i;
    it.weight      = weight_i;
    it.last        = last_i;
  end

  assign ready_o   = (cnt_q != 2'd2);
  assign push      = valid_i && ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= it;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty queue");

endmodule

>>> rtl/core/wnls_div.sv
module wnls_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] num_i,
  input  logic [23:0] den_i,
  output logic        done_o,
  output logic [47:0] quo_o
);
  import wnls_pkg::*;

  // Restoring divider, four quotient bits per cycle, in 12 steps.
  localparam int unsigned Steps = 12;
  logic [47:0] num_q, quo_q;
  logic [24:0] rem_q;
  logic [3:0]  cnt_q;
  logic        busy_q;
  logic [47:0] n_d, qo_d;
  logic [24:0] r_d;

  always_comb begin
    n_d = num_q; qo_d = quo_q; r_d = rem_q;
    for (int k = 0; k < 4; k++) begin
      r_d = {r_d[23:0], n_d[47]};
      n_d = {n_d[46:0], 1'b0};
      qo_d = {qo_d[46:0], 1'b0};
      if (r_d >= {1'b0, den_i}) begin
        r_d = r_d - {1'b0, den_i};
        qo_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i; quo_q <= '0; rem_q <= '0;
    end else if (busy_q) begin
      num_q <= n_d; quo_q <= qo_d; rem_q <= r_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'(Steps - 1)) begin
          busy_q <= 1'b0; done_o <= 1'b1;
        end
      end
    end
  end

  assign quo_o = quo_q;

endmodule

>>> rtl/core/wnls_back.sv
module wnls_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  wnls_pkg::front_item_t q_item_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic signed [63:0]    total_o,
  output logic                  sat_o
);
  import wnls_pkg::*;

  parameter int unsigned FracBits   = FracBitsDef;
  parameter int unsigned LogEntries = LogEntriesDef;
  localparam int unsigned IdxW = $clog2(LogEntries);

  localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_SQ = 4'd2, S_LN = 4'd3,
                         S_TERM = 4'd4, S_MUL = 4'd5, S_ACC = 4'd6, S_OUT = 4'd7;

  localparam logic [63:0] CConst = ((HalfLn2PiQ32 << FracBits) + (64'd1 << 31)) >> 32;
  localparam logic [47:0] QMax = (48'd256 << FracBits) - 48'd1;

  logic [15:0] tbl [LogEntries];
  always_comb begin
    for (int i = 0; i < LogEntries; i++) tbl[i] = frac_log2(i, LogEntries);
  end

  logic [3:0] st_q;
  front_item_t it_q;
  logic [47:0] q_q;
  logic [63:0] zh_q, lnm_q, tm_q, pm_q;
  logic ln_neg_q, t_neg_q;
  logic signed [63:0] sum_q;
  logic sat_q;
  logic div_start, div_done;
  logic [47:0] quo;

  // The divisor is taken from the captured transaction, since the queue head
  // moves on as soon as the transaction is taken.
  wnls_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(q_item_i.dmag_scaled),
    .den_i(it_q.sd), .done_o(div_done), .quo_o(quo)
  );

  assign q_ready_o = (st_q == S_IDLE);
  assign div_start = q_valid_i && q_ready_o;

  // Leading one and table lookup for log2(sd).
  logic [4:0] lead;
  logic [23:0] frac;
  logic [23+IdxW:0] idx_w;
  logic [IdxW-1:0] idx;
  logic signed [31:0] l2;
  logic [31:0] l2m;
  always_comb begin
    lead = '0;
    for (int b = 0; b < 24; b++) if (it_q.sd[b]) lead = 5'(b);
    frac = it_q.sd - (24'd1 << lead);
    idx_w = ({{IdxW{1'b0}}, frac} << IdxW) >> lead;
    idx = idx_w[IdxW-1:0];
    l2 = (32'(signed'({1'b0, lead})) - 32'(FracBits)) * 32'sd65536 + 32'(tbl[idx]);
    l2m = l2[31] ? 32'(-l2) : 32'(l2);
  end

  logic signed [65:0] term;
  always_comb term = -66'(signed'({1'b0, CConst}))
                     - (ln_neg_q ? -66'(signed'({1'b0, lnm_q})) : 66'(signed'({1'b0, lnm_q})))
                     - 66'(signed'({1'b0, zh_q}));

  logic signed [65:0] prod, nsum;
  always_comb begin
    prod = t_neg_q ? -66'(signed'({2'b0, pm_q})) : 66'(signed'({2'b0, pm_q}));
    nsum = 66'(sum_q) + prod;
  end

  always_ff @(posedge clk_i) begin
    if (div_start) it_q <= q_item_i;
    if (div_done) q_q <= (quo > QMax) ? QMax : quo;
    if (st_q == S_SQ) zh_q <= (64'(q_q[31:0]) * 64'(q_q[31:0])) >> (FracBits + 1);
    if (st_q == S_LN) begin
      lnm_q <= (64'(l2m) * 64'(Ln2Q32)) >> (48 - FracBits);
      ln_neg_q <= l2[31];
    end
    if (st_q == S_TERM) begin
      t_neg_q <= term[65];
      tm_q <= term[65] ? 64'(-term) : 64'(term);
    end
    if (st_q == S_MUL) pm_q <= (64'(tm_q[39:0]) * 64'(it_q.weight)) >> 16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; sum_q <= '0; sat_q <= 1'b0; valid_o <= 1'b0;
      total_o <= '0; sat_o <= 1'b0;
    end else begin
      if (valid_o && ready_i && st_q != S_OUT) valid_o <= 1'b0;
      case (st_q)
        S_IDLE: if (div_start) st_q <= S_DIV;
        S_DIV: if (div_done) begin
          st_q <= S_SQ;
          if (quo > QMax) sat_q <= 1'b1;
        end
        S_SQ:   st_q <= S_LN;
        S_LN:   st_q <= S_TERM;
        S_TERM: st_q <= S_MUL;
        S_MUL:  st_q <= S_ACC;
        S_ACC: begin
          if (nsum > 66'sd9223372036854775807) begin
            sum_q <= 64'h7FFF_FFFF_FFFF_FFFF; sat_q <= 1'b1;
          end else if (nsum < -66'sd9223372036854775808) begin
            sum_q <= 64'h8000_0000_0000_0000; sat_q <= 1'b1;
          end else begin
            sum_q <= nsum[63:0];
          end
          st_q <= it_q.last ? S_OUT : S_IDLE;
        end
        S_OUT: if (!valid_o || ready_i) begin
          valid_o <= 1'b1; total_o <= sum_q; sat_o <= sat_q;
          sum_q <= '0; sat_q <= 1'b0; st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(total_o)) else $error("result dropped");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> st_q == S_IDLE) else $error("take while busy");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_OUT && (!valid_o || ready_i) |=> sum_q == '0) else $error("sum not cleared");

endmodule

>>> rtl/core/weighted_normal_loglik_sum.sv
// Channel | Direction | Signals
// input   | in        | in_valid_i/in_ready_o, trait_point_i, person_mean_i, person_sd_i,
//         |           | post_weight_i, last_pair_i
// output  | out       | out_valid_o/out_ready_i, loglik_total_o, sum_saturated_o
//
// Each transaction passes through the back part in order: the radix-16
// quotient divider (12 steps, then done), then square, log, term,
// weight multiply and accumulate steps.
// A two-entry queue lets the front side accept while the back side works.
// The last transaction of a run also passes through the output-register state,
// and waits there while an earlier result has not yet been accepted.
// Reset is asynchronous and active low; it clears the sum and the flag.
module weighted_normal_loglik_sum #(
  parameter int unsigned FracBits   = wnls_pkg::FracBitsDef,
  parameter int unsigned LogEntries = wnls_pkg::LogEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] trait_point_i,
  input  logic signed [23:0] person_mean_i,
  input  logic [23:0]        person_sd_i,
  input  logic [16:0]        post_weight_i,
  input  logic               last_pair_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] loglik_total_o,
  output logic               sum_saturated_o
);
  import wnls_pkg::*;

  // Front part: sd cleanup and difference magnitude, into the queue.
  front_item_t q_item;
  logic q_valid, q_ready;

  wnls_front #(.FracBits(FracBits)) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(in_valid_i), .ready_o(in_ready_o),
    .trait_i(trait_point_i), .mean_i(person_mean_i), .sd_i(person_sd_i),
    .weight_i(post_weight_i), .last_i(last_pair_i),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  // Back part: divide, log, weight and saturating accumulate.
  wnls_back #(.FracBits(FracBits), .LogEntries(LogEntries)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_item_i(q_item), .valid_o(out_valid_o), .ready_i(out_ready_i),
    .total_o(loglik_total_o), .sat_o(sum_saturated_o)
  );

endmodule
